// ===== rtl/core/fractional_pll_divider_planner_assert.svh =====
// Assertion helpers for the divider planner.
// Both expect clk and arst_n to be visible where they are used.
`ifndef FRACTIONAL_PLL_DIVIDER_PLANNER_ASSERT_SVH
`define FRACTIONAL_PLL_DIVIDER_PLANNER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPDP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpdp_pkg.sv =====
package fpdp_pkg;

	localparam int NUM_W = 64;
	localparam int DEN_W = 40;
	localparam int F_W   = 35;
	localparam int N_W   = 38;

	localparam logic [25:0] XTAL_OK_HZ      = 26'd24000000;
	localparam logic [31:0] OUT_MAX_HZ      = 32'd225000000;
	localparam logic [35:0] VCO_HALF_CENTI  = 36'd45000000000;
	localparam logic [31:0] XTAL_CENTI      = 32'd2400000000;
	localparam logic [31:0] XTAL_HALF_CENTI = 32'd1200000000;
	localparam logic [6:0]  DIV_MIN         = 7'd4;
	localparam logic [6:0]  DIV_MAX         = 7'd126;
	localparam logic [17:0] P1_OFFSET       = 18'd512;
	localparam logic [31:0] CENTI           = 32'd100;

	localparam logic CFG_CRYSTAL = 1'b0;
	localparam logic CFG_MIN_OUT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LOW  = 2'd1,
		ST_HIGH = 2'd2,
		ST_XTAL = 2'd3
	} status_code_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_OD_WAIT, S_VCO, S_CF_TEST, S_CF_WAIT, S_CF_UPD,
		S_K_START, S_K_WAIT, S_SEMI, S_SEMI_MUL, S_CHOOSE, S_M_START, S_M_WAIT,
		S_T_START, S_T_WAIT, S_A_MUL, S_A_START, S_A_WAIT, S_FINISH
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_OD_TAKE, OP_VCO_INIT, OP_CF_MUL, OP_CF_UPD, OP_K_MUL,
		OP_SEMI, OP_SEMI_MUL, OP_CHOOSE, OP_M_TAKE, OP_T_TAKE, OP_A_MUL, OP_A_TAKE,
		OP_OUT_LOAD
	} dp_op_t;

	typedef enum logic [2:0] {
		DS_OUTDIV, DS_CF, DS_K, DS_MULT, DS_T, DS_ACH
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		logic     div_start;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic div_done;
		logic qn_over;
		logic d_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/fractional_pll_divider_planner.sv =====
// Plans fractional-N synthesizer settings for one requested frequency per transaction:
// even output divider, PLL ratio as a bounded continued fraction, P1/P2/P3 words and the
// achieved frequency in 0.01 Hz. One request is in flight at a time; the next one is taken
// as soon as the current result sits in the output register. All division runs on one shared
// restoring divider with a 64-bit dividend: each continued-fraction step is one divider pass, and the
// expansion runs up to about 30 steps at a 20-bit denominator bound, plus five further
// divider passes; a rejected request skips every divider pass.
// Configuration writes are always accepted (cfg_ready is tied high) and must be issued idle.
`include "fractional_pll_divider_planner_assert.svh"

module fractional_pll_divider_planner #(
	parameter int DENOM_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] freq_hz,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [17:0] pll_p1,
	output logic [19:0] pll_p2,
	output logic [19:0] pll_p3,
	output logic [5:0]  pll_mult,
	output logic [19:0] pll_num,
	output logic [6:0]  out_divider,
	output logic        divide_by_four,
	output logic [6:0]  quadrature_phase,
	output logic [34:0] achieved_centihz,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	fpdp_pkg::dp_cmd_t    cmd;
	fpdp_pkg::dp_status_t sts;

	assign cfg_ready = 1'b1;

	fpdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpdp_datapath #(
		.DENOM_BITS (DENOM_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.freq_hz          (freq_hz),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.status           (status),
		.pll_p1           (pll_p1),
		.pll_p2           (pll_p2),
		.pll_p3           (pll_p3),
		.pll_mult         (pll_mult),
		.pll_num          (pll_num),
		.out_divider      (out_divider),
		.divide_by_four   (divide_by_four),
		.quadrature_phase (quadrature_phase),
		.achieved_centihz (achieved_centihz)
	);

	`FPDP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready,
		"input taken while a request is in flight")
	`FPDP_ASSERT_SAME(a_reject_zero, out_valid && status != fpdp_pkg::ST_OK,
		pll_p3 == '0 && out_divider == '0 && achieved_centihz == '0 && pll_p1 == '0,
		"rejected request carries nonzero settings")
	`FPDP_ASSERT_SAME(a_div_range, out_valid && status == fpdp_pkg::ST_OK,
		out_divider >= 7'd4 && out_divider <= 7'd126 && !out_divider[0] && pll_p3 != '0,
		"accepted plan has bad divider or zero denominator")
	`FPDP_ASSERT_SAME(a_div4_flag, out_valid,
		divide_by_four == (status == fpdp_pkg::ST_OK && out_divider == 7'd4),
		"divide-by-four flag does not match divider")

endmodule

// ===== rtl/core/fpdp_divider.sv =====
module fpdp_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fpdp_pkg::NUM_W-1:0]     numer,
	input  logic [fpdp_pkg::DEN_W-1:0]     denom,
	output logic                           done,
	output logic [fpdp_pkg::NUM_W-1:0]     quot,
	output logic [fpdp_pkg::DEN_W-1:0]     rem
);

	localparam int NW    = fpdp_pkg::NUM_W;
	localparam int DW    = fpdp_pkg::DEN_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quot_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// restoring step: one quotient bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, quot_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q  <= '0;
			den_q  <= denom;
		end else if (busy_q) begin
			quot_q <= {quot_q[NW-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/fpdp_datapath.sv =====
module fpdp_datapath #(
	parameter int DENOM_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpdp_pkg::dp_cmd_t     cmd,
	output fpdp_pkg::dp_status_t  sts,
	input  logic [31:0]           freq_hz,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [1:0]            status,
	output logic [17:0]           pll_p1,
	output logic [19:0]           pll_p2,
	output logic [19:0]           pll_p3,
	output logic [5:0]            pll_mult,
	output logic [19:0]           pll_num,
	output logic [6:0]            out_divider,
	output logic                  divide_by_four,
	output logic [6:0]            quadrature_phase,
	output logic [34:0]           achieved_centihz
);

	localparam int DB  = DENOM_BITS;
	localparam int PW  = DB + 7;
	localparam int AW  = DB + 1;
	localparam int QPW = AW + DB;
	localparam int PPW = AW + PW;
	localparam int CW  = 32 + DB;
	localparam int XW  = 32 + PW;
	localparam int BW  = DB + 7;
	localparam int NW  = fpdp_pkg::NUM_W;
	localparam int DW  = fpdp_pkg::DEN_W;
	localparam int FW  = fpdp_pkg::F_W;
	localparam int RW  = fpdp_pkg::N_W;
	localparam logic [DB-1:0] LIMIT = '1;

	// configuration
	logic [25:0] crystal_q;
	logic [27:0] min_out_q;

	// working registers
	fpdp_pkg::status_code_t status_q;
	fpdp_pkg::status_code_t status_in;
	logic [FW-1:0]  f_q;
	logic [6:0]     div_q;
	logic [RW-1:0]  n_q, d_q, r_q;
	logic [PW-1:0]  pa_q, pb_q, sn_q, bn_q;
	logic [DB-1:0]  qa_q, qb_q, sd_q, bd_q;
	logic [QPW-1:0] prodq_s1;
	logic [PPW-1:0] prodp_s1;
	logic [CW-1:0]  prodc_s1;
	logic [XW-1:0]  prodx_s1;
	logic [BW-1:0]  prodbd_s1;
	logic [5:0]     mult_q;
	logic [DB-1:0]  num_q, p2_q;
	logic [6:0]     t_q;
	logic [34:0]    ach_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  status_o_q;
	logic [17:0] p1_o_q;
	logic [19:0] p2_o_q, p3_o_q, num_o_q;
	logic [5:0]  mult_o_q;
	logic [6:0]  div_o_q;
	logic        d4_o_q;
	logic [34:0] ach_o_q;

	// divider
	logic [NW-1:0] dv_numer, dv_quot;
	logic [DW-1:0] dv_denom, dv_rem;
	logic          dv_done;

	logic [AW-1:0]  a_sat;
	logic [QPW:0]   qn;
	logic [31:0]    d_sat;
	logic [DB-1:0]  k_val;
	logic [6:0]     div_clamp;
	logic [17:0]    p1_val;

	fpdp_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (dv_numer),
		.denom  (dv_denom),
		.done   (dv_done),
		.quot   (dv_quot),
		.rem    (dv_rem)
	);

	always_comb begin
		unique case (cmd.div_sel)
			fpdp_pkg::DS_OUTDIV: begin
				dv_numer = NW'(fpdp_pkg::VCO_HALF_CENTI);
				dv_denom = DW'(f_q);
			end
			fpdp_pkg::DS_CF: begin
				dv_numer = NW'(n_q);
				dv_denom = DW'(d_q);
			end
			fpdp_pkg::DS_K: begin
				dv_numer = NW'(LIMIT - qa_q);
				dv_denom = DW'(qb_q);
			end
			fpdp_pkg::DS_MULT: begin
				dv_numer = NW'(bn_q);
				dv_denom = DW'(bd_q);
			end
			fpdp_pkg::DS_T: begin
				dv_numer = NW'({num_q, 7'b0});
				dv_denom = DW'(bd_q);
			end
			fpdp_pkg::DS_ACH: begin
				dv_numer = NW'(prodx_s1);
				dv_denom = DW'(prodbd_s1);
			end
			default: begin
				dv_numer = '0;
				dv_denom = '0;
			end
		endcase
	end

	always_comb begin
		if (freq_hz == '0)
			status_in = fpdp_pkg::ST_LOW;
		else if (crystal_q != fpdp_pkg::XTAL_OK_HZ)
			status_in = fpdp_pkg::ST_XTAL;
		else if (freq_hz < 32'(min_out_q))
			status_in = fpdp_pkg::ST_LOW;
		else if (freq_hz > fpdp_pkg::OUT_MAX_HZ)
			status_in = fpdp_pkg::ST_HIGH;
		else
			status_in = fpdp_pkg::ST_OK;

		// a partial quotient above the bound forces the break anyway once qb >= 1
		a_sat = ((dv_quot >> AW) != '0) ? '1 : dv_quot[AW-1:0];
		qn    = (QPW+1)'(qa_q) + (QPW+1)'(prodq_s1);
		d_sat = ((d_q >> 32) != '0) ? '1 : d_q[31:0];
		k_val = dv_quot[DB-1:0];

		if (dv_quot < NW'(2))
			div_clamp = fpdp_pkg::DIV_MIN;
		else if ((dv_quot >> 6) != '0)
			div_clamp = fpdp_pkg::DIV_MAX;
		else
			div_clamp = {dv_quot[5:0], 1'b0};

		p1_val = (18'(mult_q) << 7) + 18'(t_q) - fpdp_pkg::P1_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q   <= 26'd24000000;
			min_out_q   <= 28'd1000000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					fpdp_pkg::CFG_CRYSTAL: crystal_q <= cfg_data[25:0];
					fpdp_pkg::CFG_MIN_OUT: min_out_q <= cfg_data[27:0];
					default: ;
				endcase
			end
			if (cmd.op == fpdp_pkg::OP_OUT_LOAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			fpdp_pkg::OP_LOAD: begin
				status_q <= status_in;
				f_q      <= FW'(FW'(freq_hz) * FW'(fpdp_pkg::CENTI));
			end
			fpdp_pkg::OP_OD_TAKE: div_q <= div_clamp;
			fpdp_pkg::OP_VCO_INIT: begin
				n_q  <= RW'(f_q) * RW'(div_q);
				d_q  <= RW'(fpdp_pkg::XTAL_CENTI);
				pa_q <= '0;
				qa_q <= DB'(1);
				pb_q <= PW'(1);
				qb_q <= '0;
			end
			fpdp_pkg::OP_CF_MUL: begin
				r_q      <= dv_rem[RW-1:0];
				prodq_s1 <= QPW'(a_sat) * QPW'(qb_q);
				prodp_s1 <= PPW'(a_sat) * PPW'(pb_q);
			end
			fpdp_pkg::OP_CF_UPD: begin
				pa_q <= pb_q;
				qa_q <= qb_q;
				pb_q <= PW'(PPW'(pa_q) + prodp_s1);
				qb_q <= qn[DB-1:0];
				n_q  <= d_q;
				d_q  <= r_q;
			end
			fpdp_pkg::OP_K_MUL: begin
				prodq_s1 <= QPW'(k_val) * QPW'(qb_q);
				prodp_s1 <= PPW'(k_val) * PPW'(pb_q);
			end
			fpdp_pkg::OP_SEMI: begin
				sn_q <= PW'(PPW'(pa_q) + prodp_s1);
				sd_q <= DB'(QPW'(qa_q) + prodq_s1);
			end
			fpdp_pkg::OP_SEMI_MUL: prodc_s1 <= CW'(d_sat) * CW'(sd_q);
			fpdp_pkg::OP_CHOOSE: begin
				// 2*d*sd <= xtal, with xtal even
				if (prodc_s1 <= CW'(fpdp_pkg::XTAL_HALF_CENTI)) begin
					bn_q <= pb_q;
					bd_q <= qb_q;
				end else begin
					bn_q <= sn_q;
					bd_q <= sd_q;
				end
			end
			fpdp_pkg::OP_M_TAKE: begin
				mult_q <= dv_quot[5:0];
				num_q  <= dv_rem[DB-1:0];
			end
			fpdp_pkg::OP_T_TAKE: begin
				t_q  <= dv_quot[6:0];
				p2_q <= dv_rem[DB-1:0];
			end
			fpdp_pkg::OP_A_MUL: begin
				prodx_s1  <= XW'(fpdp_pkg::XTAL_CENTI) * XW'(bn_q);
				prodbd_s1 <= BW'(bd_q) * BW'(div_q);
			end
			fpdp_pkg::OP_A_TAKE: ach_q <= dv_quot[34:0];
			fpdp_pkg::OP_OUT_LOAD: begin
				status_o_q <= status_q;
				if (status_q == fpdp_pkg::ST_OK) begin
					p1_o_q   <= p1_val;
					p2_o_q   <= 20'(p2_q);
					p3_o_q   <= 20'(bd_q);
					mult_o_q <= mult_q;
					num_o_q  <= 20'(num_q);
					div_o_q  <= div_q;
					d4_o_q   <= (div_q == fpdp_pkg::DIV_MIN);
					ach_o_q  <= ach_q;
				end else begin
					p1_o_q   <= '0;
					p2_o_q   <= '0;
					p3_o_q   <= '0;
					mult_o_q <= '0;
					num_o_q  <= '0;
					div_o_q  <= '0;
					d4_o_q   <= 1'b0;
					ach_o_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.ok       = (status_q == fpdp_pkg::ST_OK);
		sts.div_done = dv_done;
		sts.qn_over  = qn > (QPW+1)'(LIMIT);
		sts.d_zero   = (d_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid        = out_valid_q;
	assign status           = status_o_q;
	assign pll_p1           = p1_o_q;
	assign pll_p2           = p2_o_q;
	assign pll_p3           = p3_o_q;
	assign pll_mult         = mult_o_q;
	assign pll_num          = num_o_q;
	assign out_divider      = div_o_q;
	assign divide_by_four   = d4_o_q;
	assign quadrature_phase = div_o_q;
	assign achieved_centihz = ach_o_q;

endmodule

// ===== rtl/core/fpdp_ctrl.sv =====
module fpdp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fpdp_pkg::dp_status_t sts,
	output fpdp_pkg::dp_cmd_t    cmd
);

	fpdp_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fpdp_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.op        = fpdp_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = fpdp_pkg::DS_CF;
		unique case (state_q)
			fpdp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = fpdp_pkg::OP_LOAD;
					state_d = fpdp_pkg::S_CHECK;
				end
			end
			fpdp_pkg::S_CHECK: begin
				if (!sts.ok) begin
					state_d = fpdp_pkg::S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fpdp_pkg::DS_OUTDIV;
					state_d       = fpdp_pkg::S_OD_WAIT;
				end
			end
			fpdp_pkg::S_OD_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_OD_TAKE;
					state_d = fpdp_pkg::S_VCO;
				end
			end
			fpdp_pkg::S_VCO: begin
				cmd.op  = fpdp_pkg::OP_VCO_INIT;
				state_d = fpdp_pkg::S_CF_TEST;
			end
			fpdp_pkg::S_CF_TEST: begin
				if (sts.d_zero) begin
					state_d = fpdp_pkg::S_K_START;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fpdp_pkg::DS_CF;
					state_d       = fpdp_pkg::S_CF_WAIT;
				end
			end
			fpdp_pkg::S_CF_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_CF_MUL;
					state_d = fpdp_pkg::S_CF_UPD;
				end
			end
			fpdp_pkg::S_CF_UPD: begin
				// next denominator over the bound ends the expansion
				if (sts.qn_over) begin
					state_d = fpdp_pkg::S_K_START;
				end else begin
					cmd.op  = fpdp_pkg::OP_CF_UPD;
					state_d = fpdp_pkg::S_CF_TEST;
				end
			end
			fpdp_pkg::S_K_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = fpdp_pkg::DS_K;
				state_d       = fpdp_pkg::S_K_WAIT;
			end
			fpdp_pkg::S_K_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_K_MUL;
					state_d = fpdp_pkg::S_SEMI;
				end
			end
			fpdp_pkg::S_SEMI: begin
				cmd.op  = fpdp_pkg::OP_SEMI;
				state_d = fpdp_pkg::S_SEMI_MUL;
			end
			fpdp_pkg::S_SEMI_MUL: begin
				cmd.op  = fpdp_pkg::OP_SEMI_MUL;
				state_d = fpdp_pkg::S_CHOOSE;
			end
			fpdp_pkg::S_CHOOSE: begin
				cmd.op  = fpdp_pkg::OP_CHOOSE;
				state_d = fpdp_pkg::S_M_START;
			end
			fpdp_pkg::S_M_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = fpdp_pkg::DS_MULT;
				state_d       = fpdp_pkg::S_M_WAIT;
			end
			fpdp_pkg::S_M_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_M_TAKE;
					state_d = fpdp_pkg::S_T_START;
				end
			end
			fpdp_pkg::S_T_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = fpdp_pkg::DS_T;
				state_d       = fpdp_pkg::S_T_WAIT;
			end
			fpdp_pkg::S_T_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_T_TAKE;
					state_d = fpdp_pkg::S_A_MUL;
				end
			end
			fpdp_pkg::S_A_MUL: begin
				cmd.op  = fpdp_pkg::OP_A_MUL;
				state_d = fpdp_pkg::S_A_START;
			end
			fpdp_pkg::S_A_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = fpdp_pkg::DS_ACH;
				state_d       = fpdp_pkg::S_A_WAIT;
			end
			fpdp_pkg::S_A_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = fpdp_pkg::OP_A_TAKE;
					state_d = fpdp_pkg::S_FINISH;
				end
			end
			fpdp_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = fpdp_pkg::OP_OUT_LOAD;
					state_d = fpdp_pkg::S_IDLE;
				end
			end
			default: state_d = fpdp_pkg::S_IDLE;
		endcase
	end

endmodule
